[design/stop_wait_arq_sender_top_defines.svh]
// Assertion macros for the stop-and-wait ARQ sender.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef STOP_WAIT_ARQ_SENDER_TOP_DEFINES_SVH
`define STOP_WAIT_ARQ_SENDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define SWARQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SWARQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/swarq_pkg.sv]
// Types and codes shared by the stop-and-wait ARQ sender.
// No dependencies.
package swarq_pkg;

    // Event opcodes.
    localparam logic [1:0] OP_SEND  = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result actions.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_NEW     = 3'd1;
    localparam logic [2:0] ACT_TIMEOUT = 3'd2;
    localparam logic [2:0] ACT_FAST    = 3'd3;
    localparam logic [2:0] ACT_DONE    = 3'd4;
    localparam logic [2:0] ACT_REJECT  = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_DUP_ACK_LIMIT = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    // Configuration reset values.
    localparam logic [7:0]  DUP_ACK_LIMIT_RST = 8'd3;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

    // Input event item.
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] payload_len;
        logic       crc_ok;
        logic       is_ack;
        logic [7:0] ack_seq;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [2:0] action;
        logic       frame_seq;
        logic [7:0] frame_len;
        logic       busy_res;
    } out_item_t;

endpackage

[design/stop_wait_arq_sender_top.sv]
// An accepted item waits in the input register for a free result slot; then its result is registered.
// One item per cycle unless results stall; the whole state update fits between the two registers.
// A stalled result does not block the input register until the next item needs the result slot.
// Reset: aresetn is synchronous and active low; it clears the ARQ state and the valid flags
// and loads the configuration defaults (duplicate ack limit 3, timeout 1000 ticks).
`include "stop_wait_arq_sender_top_defines.svh"

module stop_wait_arq_sender_top
    import swarq_pkg::*;
#(
    parameter int MAX_PAYLOAD = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

    logic        in_valid_reg;
    in_item_t    in_data_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic [7:0]  dup_ack_limit_reg;
    logic [15:0] timeout_ticks_reg;

    logic        seq_bit_reg, seq_bit_next;
    logic        waiting_reg, waiting_next;
    logic [7:0]  stored_len_reg, stored_len_next;
    logic [7:0]  dup_count_reg, dup_count_next;
    logic [15:0] tick_count_reg, tick_count_next;

    out_item_t   res;
    logic        fire;
    logic [7:0]  len_sat;
    logic [15:0] tick_inc;

    // The held item is processed when the result slot is free or being emptied.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign len_sat  = (in_data_reg.payload_len > MaxLen) ? MaxLen : in_data_reg.payload_len;
    assign tick_inc = tick_count_reg + 16'd1;

    // Event handling against the current ARQ state.
    always_comb begin
        seq_bit_next    = seq_bit_reg;
        waiting_next    = waiting_reg;
        stored_len_next = stored_len_reg;
        dup_count_next  = dup_count_reg;
        tick_count_next = tick_count_reg;
        res.action      = ACT_NONE;
        res.frame_seq   = 1'b0;
        res.frame_len   = 8'd0;
        res.busy_res    = waiting_reg;
        case (in_data_reg.opcode)
            OP_SEND: begin
                if (waiting_reg) begin
                    res.action = ACT_REJECT;
                end else begin
                    stored_len_next = len_sat;
                    waiting_next    = 1'b1;
                    dup_count_next  = 8'd0;
                    tick_count_next = 16'd0;
                    res.action      = ACT_NEW;
                    res.frame_seq   = seq_bit_reg;
                    res.frame_len   = len_sat;
                    res.busy_res    = 1'b1;
                end
            end
            OP_FRAME: begin
                if (waiting_reg) begin
                    if (!in_data_reg.crc_ok || !in_data_reg.is_ack) begin
                        // A corrupt or non-ack frame is handled like a timeout.
                        tick_count_next = 16'd0;
                        res.action      = ACT_TIMEOUT;
                        res.frame_seq   = seq_bit_reg;
                        res.frame_len   = stored_len_reg;
                    end else if (in_data_reg.ack_seq == {7'd0, seq_bit_reg}) begin
                        seq_bit_next = ~seq_bit_reg;
                        waiting_next = 1'b0;
                        res.action   = ACT_DONE;
                        res.busy_res = 1'b0;
                    end else if (dup_count_reg == dup_ack_limit_reg) begin
                        dup_count_next  = 8'd0;
                        tick_count_next = 16'd0;
                        res.action      = ACT_FAST;
                        res.frame_seq   = seq_bit_reg;
                        res.frame_len   = stored_len_reg;
                    end else begin
                        dup_count_next = dup_count_reg + 8'd1;
                    end
                end
            end
            OP_TICK: begin
                if (waiting_reg) begin
                    if (tick_inc >= timeout_ticks_reg) begin
                        tick_count_next = 16'd0;
                        res.action      = ACT_TIMEOUT;
                        res.frame_seq   = seq_bit_reg;
                        res.frame_len   = stored_len_reg;
                    end else begin
                        tick_count_next = tick_inc;
                    end
                end
            end
            default: begin
                res.action = ACT_NONE;
            end
        endcase
    end

    // Control state, configuration and ARQ state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            dup_ack_limit_reg <= DUP_ACK_LIMIT_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            seq_bit_reg       <= 1'b0;
            waiting_reg       <= 1'b0;
            stored_len_reg    <= 8'd0;
            dup_count_reg     <= 8'd0;
            tick_count_reg    <= 16'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                if (cfg_index == CFG_DUP_ACK_LIMIT) begin
                    dup_ack_limit_reg <= cfg_wdata[7:0];
                end else begin
                    timeout_ticks_reg <= cfg_wdata;
                end
            end
            if (fire) begin
                seq_bit_reg    <= seq_bit_next;
                waiting_reg    <= waiting_next;
                stored_len_reg <= stored_len_next;
                dup_count_reg  <= dup_count_next;
                tick_count_reg <= tick_count_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= res;
        end
    end

    // Checks on the ARQ logic.
    `SWARQ_ASSERT_NOW(a_len_bound, aclk, aresetn, m_valid, m_data.frame_len <= MaxLen,
        "frame length above maximum payload")
    `SWARQ_ASSERT_NOW(a_tx_busy, aclk, aresetn,
        m_valid && (m_data.action == ACT_NEW || m_data.action == ACT_TIMEOUT
            || m_data.action == ACT_FAST),
        m_data.busy_res, "transmit result while not waiting")
    `SWARQ_ASSERT_NOW(a_done_clean, aclk, aresetn, m_valid && m_data.action == ACT_DONE,
        !m_data.busy_res && m_data.frame_len == 8'd0 && !m_data.frame_seq,
        "done result carries frame fields")
    `SWARQ_ASSERT_NEXT(a_seq_hold, aclk, aresetn, !(fire && res.action == ACT_DONE),
        $stable(seq_bit_reg), "sequence bit changed without completion")
    `SWARQ_ASSERT_NEXT(a_send_waits, aclk, aresetn, fire && in_data_reg.opcode == OP_SEND,
        waiting_reg, "send request left the sender idle")

endmodule

[bench/testbench.sv]
// Self-checking testbench for the stop-and-wait ARQ sender (stop_wait_arq_sender_top).
// Drives link events through the valid/ready input, predicts every result, checks the outputs.
// Depends on swarq_pkg and the RTL under design/.
module testbench;
    import swarq_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [7:0] PAYLOAD_MAX = 8'd128;
    localparam int         PRED        = 0;
    localparam int         PLAN        = 1;
    localparam int         HOLD_CYCLES = 300;
    localparam int         QUIET_LIMIT = 2000;

    // Sender state, kept once for the checker and once for the stimulus planner.
    typedef struct packed {
        logic        seq_bit;
        logic        waiting;
        logic [7:0]  stored_len;
        logic [7:0]  dup_count;
        logic [15:0] tick_count;
    } arq_state_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;

    arq_state_t  arq_st [2];
    logic [7:0]  dup_limit_sh  = DUP_ACK_LIMIT_RST;
    logic [15:0] tick_limit_sh = TIMEOUT_TICKS_RST;

    in_item_t    link_events_q [$];
    out_item_t   sender_results_q [$];
    int unsigned queued_items;
    int unsigned mismatch_count = 0;
    int unsigned send_gap_pct   = 26;
    int unsigned recv_stall_pct = 26;
    int unsigned hold_asks      = 0;
    int unsigned hold_taken     = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;
    logic        in_fire        = 1'b0;

    stop_wait_arq_sender_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Advance one sender state by one link event and return the result it causes.
    function automatic out_item_t sender_step(input int who, input in_item_t ev);
        arq_state_t st;
        out_item_t  res;
        st = arq_st[who];
        res = '0;
        res.action = ACT_NONE;
        if (ev.opcode == OP_SEND) begin
            if (st.waiting) begin
                res.action = ACT_REJECT;
            end else begin
                st.stored_len = (ev.payload_len > PAYLOAD_MAX) ? PAYLOAD_MAX : ev.payload_len;
                st.waiting    = 1'b1;
                st.dup_count  = '0;
                st.tick_count = '0;
                res.action    = ACT_NEW;
            end
        end else if (st.waiting && ev.opcode == OP_FRAME) begin
            if (!ev.crc_ok || !ev.is_ack) begin
                // A damaged or non-ack frame is handled like a timeout.
                st.tick_count = '0;
                res.action    = ACT_TIMEOUT;
            end else if (ev.ack_seq == {7'd0, st.seq_bit}) begin
                st.seq_bit = ~st.seq_bit;
                st.waiting = 1'b0;
                res.action = ACT_DONE;
            end else if (st.dup_count == dup_limit_sh) begin
                st.dup_count  = '0;
                st.tick_count = '0;
                res.action    = ACT_FAST;
            end else begin
                st.dup_count = st.dup_count + 8'd1;
            end
        end else if (st.waiting && ev.opcode == OP_TICK) begin
            st.tick_count = st.tick_count + 16'd1;
            if (st.tick_count >= tick_limit_sh) begin
                st.tick_count = '0;
                res.action    = ACT_TIMEOUT;
            end
        end
        if (res.action == ACT_NEW || res.action == ACT_TIMEOUT || res.action == ACT_FAST) begin
            res.frame_seq = st.seq_bit;
            res.frame_len = st.stored_len;
        end
        res.busy_res = st.waiting;
        arq_st[who] = st;
        return res;
    endfunction

    // Input side: take a new item from the queue when the slot is free, with random gaps.
    always @(negedge aclk) begin
        if (!s_valid || in_fire) begin
            if (link_events_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                s_data  <= link_events_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Predict the result of every accepted item.
    always @(posedge aclk) begin
        in_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            sender_results_q.push_back(sender_step(PRED, s_data));
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked for.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asks) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= hold_taken + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sender_results_q.size() == 0) begin
                $error("result with no item pending: action %0d", m_data.action);
                mismatch_count++;
            end else begin
                want = sender_results_q.pop_front();
                if (m_data.action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, m_data.action);
                    mismatch_count++;
                end
                if (m_data.frame_seq !== want.frame_seq) begin
                    $error("frame_seq: expected %0d, got %0d", want.frame_seq, m_data.frame_seq);
                    mismatch_count++;
                end
                if (m_data.frame_len !== want.frame_len) begin
                    $error("frame_len: expected %0d, got %0d", want.frame_len, m_data.frame_len);
                    mismatch_count++;
                end
                if (m_data.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, m_data.busy_res);
                    mismatch_count++;
                end
            end
        end
    end

    // Count cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // Queue one item and advance the planner so later items can follow the protocol.
    task automatic add_event(input in_item_t ev);
        void'(sender_step(PLAN, ev));
        link_events_q.push_back(ev);
        queued_items++;
    endtask

    // An item of the given opcode with every other field random.
    function automatic in_item_t noise_item(input logic [1:0] op);
        in_item_t ev;
        ev.opcode      = op;
        ev.payload_len = 8'($urandom_range(255));
        ev.crc_ok      = 1'($urandom_range(1));
        ev.is_ack      = 1'($urandom_range(1));
        ev.ack_seq     = 8'($urandom_range(255));
        return ev;
    endfunction

    task automatic add_send(input logic [7:0] len);
        in_item_t ev;
        ev = noise_item(OP_SEND);
        ev.payload_len = len;
        add_event(ev);
    endtask

    task automatic add_frame(input logic crc, input logic ack, input logic [7:0] seq);
        in_item_t ev;
        ev = noise_item(OP_FRAME);
        ev.crc_ok  = crc;
        ev.is_ack  = ack;
        ev.ack_seq = seq;
        add_event(ev);
    endtask

    task automatic add_tick();
        add_event(noise_item(OP_TICK));
    endtask

    task automatic add_unused();
        add_event(noise_item(OP_UNUSED));
    endtask

    task automatic add_good_ack();
        add_frame(1'b1, 1'b1, {7'd0, arq_st[PLAN].seq_bit});
    endtask

    // A sequence byte that does not match the frame in flight.
    function automatic logic [7:0] wrong_seq();
        logic [7:0] s;
        if ($urandom_range(1) != 0)
            s = {7'd0, ~arq_st[PLAN].seq_bit};
        else
            s = 8'($urandom_range(255));
        if (s == {7'd0, arq_st[PLAN].seq_bit})
            s[7] = 1'b1;
        return s;
    endfunction

    // Payload lengths weighted toward the saturation boundary.
    function automatic logic [7:0] pick_len();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'($urandom_range(129, 127));
            2:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One send, a run of disturbances while waiting, and usually the closing ack.
    task automatic run_exchange(input int unsigned max_events);
        int unsigned n;
        int unsigned pick;
        add_send(pick_len());
        n = $urandom_range(max_events);
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 40)
                add_tick();
            else if (pick < 65)
                add_frame(1'b1, 1'b1, wrong_seq());
            else if (pick < 75)
                add_frame(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
            else if (pick < 83)
                add_frame(1'b1, 1'b0, 8'($urandom_range(255)));
            else if (pick < 93)
                add_send(pick_len());
            else
                add_unused();
        end
        if ($urandom_range(9) != 0)
            add_good_ack();
    endtask

    // Wait until every item has been accepted and every result checked.
    task automatic settle();
        do @(posedge aclk);
        while (link_events_q.size() != 0 || s_valid || sender_results_q.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_DUP_ACK_LIMIT)
            dup_limit_sh = value[7:0];
        else
            tick_limit_sh = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input logic [7:0] limit, input logic [15:0] ticks,
                                input int unsigned n_items, input int unsigned gap_pct,
                                input bit hold);
        settle();
        write_reg(CFG_DUP_ACK_LIMIT, {8'd0, limit});
        write_reg(CFG_TIMEOUT_TICKS, ticks);
        send_gap_pct   = hold ? 0 : gap_pct;
        recv_stall_pct = gap_pct;
        if (hold)
            hold_asks++;
        queued_items = 0;
        while (queued_items < n_items) begin
            // Stray events, usually while the sender is idle.
            if ($urandom_range(4) == 0) begin
                case ($urandom_range(2))
                    0:       add_tick();
                    1:       add_frame(1'($urandom_range(1)), 1'($urandom_range(1)),
                                       8'($urandom_range(255)));
                    default: add_unused();
                endcase
            end
            run_exchange((ticks <= 16'd8) ? 12 : 6);
        end
    endtask

    initial begin
        arq_st[PRED] = '0;
        arq_st[PLAN] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: saturated request, a tick far below the timeout, clean ack.
        add_send(8'd200);
        add_tick();
        add_good_ack();

        // Directed cases with a small limit and a short timeout.
        settle();
        write_reg(CFG_DUP_ACK_LIMIT, 16'd1);
        write_reg(CFG_TIMEOUT_TICKS, 16'd2);
        add_tick();
        add_frame(1'b1, 1'b1, 8'd1);
        add_unused();
        add_send(8'd0);
        add_send(8'd255);
        add_unused();
        add_frame(1'b0, 1'b1, {7'd0, arq_st[PLAN].seq_bit});
        add_frame(1'b1, 1'b0, {7'd0, arq_st[PLAN].seq_bit});
        add_frame(1'b1, 1'b1, {7'd0, ~arq_st[PLAN].seq_bit});
        add_frame(1'b1, 1'b1, 8'hFE);
        add_tick();
        add_tick();
        add_good_ack();
        add_send(8'd128);
        add_good_ack();
        add_send(8'd129);
        add_good_ack();
        add_send(8'd127);
        add_good_ack();

        // Limit lowered while a frame is in flight: the duplicate count runs past it and wraps.
        settle();
        write_reg(CFG_DUP_ACK_LIMIT, 16'd5);
        write_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
        add_send(pick_len());
        repeat (3) add_frame(1'b1, 1'b1, wrong_seq());
        settle();
        write_reg(CFG_DUP_ACK_LIMIT, 16'd1);
        repeat (260) add_frame(1'b1, 1'b1, wrong_seq());
        add_good_ack();

        // Random phases across the register range.
        random_phase(8'd3,   16'd5,     200, 26, 1'b0);
        random_phase(8'd0,   16'd0,     180, 26, 1'b0);
        random_phase(8'd255, 16'd3,     200, 0,  1'b0);
        random_phase(8'd2,   16'd1,     200, 26, 1'b1);
        random_phase(8'd1,   16'hFFFF,  150, 26, 1'b0);
        random_phase(8'd7,   16'd8,     200, 26, 1'b0);
        random_phase(8'd255, 16'd1000,  120, 26, 1'b0);

        settle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && sender_results_q.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
